[src/srg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package srg_pkg;

    // default fixed point format
    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // configuration register map
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LIGHT_X = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LIGHT_Y = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LIGHT_Z = 2'd2;

endpackage

`default_nettype wire

[src/srg_point_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

module srg_point_lane import srg_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic                         hit,
    input  wire logic signed [COORD_BITS-1:0] t,
    input  wire logic signed [COORD_BITS-1:0] org,
    input  wire logic signed [COORD_BITS-1:0] dir,
    input  wire logic signed [COORD_BITS-1:0] light,
    output logic signed [COORD_BITS-1:0]      vec,
    output logic                              sat
);

    localparam int W  = COORD_BITS;
    localparam int PW = 2 * COORD_BITS;
    localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [PW-1:0] HALF = PW'(1) << (W - 1);

    // stage 1 registers: magnitude product
    logic [PW-1:0]      prod1_reg;
    logic               neg1_reg;
    logic [W-1:0]       org1_reg;
    logic               hit1_reg;
    // stage 2 registers: scaled product
    logic [W-1:0]       prod2_reg;
    logic               sat2_reg;
    logic [W-1:0]       org2_reg;
    logic               hit2_reg;
    // stage 3 registers: hit point
    logic [W-1:0]       pt3_reg;
    logic               sat3_reg;
    logic               hit3_reg;
    // stage 4 registers: light to hit vector
    logic [W-1:0]       vec4_reg;
    logic               sat4_reg;

    logic [W-1:0]  mag_dir;
    logic [W-1:0]  mag_t;
    logic [PW-1:0] q_scaled;
    logic [PW-1:0] q_limit;
    logic [W-1:0]  prod2_next;
    logic          sat2_next;
    logic [W:0]    sum3;
    logic [W-1:0]  pt3_next;
    logic          ovf3;
    logic [W:0]    diff4;
    logic [W-1:0]  vec4_next;
    logic          ovf4;

    // operand magnitudes
    assign mag_dir = dir[W-1] ? (~dir + W'(1)) : dir;
    assign mag_t   = t[W-1] ? (~t + W'(1)) : t;

    // truncate the product and clamp to range
    always_comb
    begin
        q_scaled = prod1_reg >> FRAC_BITS;
        q_limit  = neg1_reg ? HALF : HALF - PW'(1);
        if (q_scaled > q_limit)
        begin
            sat2_next  = 1'b1;
            prod2_next = neg1_reg ? VMIN : VMAX;
        end
        else
        begin
            sat2_next  = 1'b0;
            prod2_next = neg1_reg ? (~q_scaled[W-1:0] + W'(1)) : q_scaled[W-1:0];
        end
    end

    // saturating origin plus product
    always_comb
    begin
        sum3 = {org2_reg[W-1], org2_reg} + {prod2_reg[W-1], prod2_reg};
        ovf3 = sum3[W] != sum3[W-1];
        pt3_next = ovf3 ? (sum3[W] ? VMIN : VMAX) : sum3[W-1:0];
    end

    // saturating hit point minus light
    always_comb
    begin
        diff4 = {pt3_reg[W-1], pt3_reg} - {light[W-1], light};
        ovf4  = diff4[W] != diff4[W-1];
        vec4_next = ovf4 ? (diff4[W] ? VMIN : VMAX) : diff4[W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod1_reg <= PW'(mag_dir) * PW'(mag_t);
            neg1_reg  <= dir[W-1] ^ t[W-1];
            org1_reg  <= org;
            hit1_reg  <= hit;

            prod2_reg <= prod2_next;
            sat2_reg  <= sat2_next;
            org2_reg  <= org1_reg;
            hit2_reg  <= hit1_reg;

            pt3_reg   <= pt3_next;
            sat3_reg  <= sat2_reg | ovf3;
            hit3_reg  <= hit2_reg;

            // a miss gives a zero vector and no clamp of its own
            vec4_reg  <= hit3_reg ? vec4_next : '0;
            sat4_reg  <= hit3_reg & (sat3_reg | ovf4);
        end
    end

    assign vec = vec4_reg;
    assign sat = sat4_reg;

endmodule

`default_nettype wire

[src/srg_recip_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

module srg_recip_lane import srg_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic signed [COORD_BITS-1:0] vec_in,
    input  wire logic                         sat_in,
    output logic signed [COORD_BITS-1:0]      vec_out,
    output logic signed [COORD_BITS-1:0]      inv,
    output logic                              sat
);

    localparam int W  = COORD_BITS;
    localparam int QW = 2 * FRAC_BITS + 1;
    localparam int CW = ((QW > W) ? QW : W) + 1;
    localparam logic [W-1:0]  VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  VMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [CW-1:0] HALF = CW'(1) << (W - 1);

    // per stage registers, entry 0 is the operand set-up stage
    logic [W:0]    rem_reg  [0:QW];
    logic [QW-1:0] quo_reg  [0:QW];
    logic [W-1:0]  mag_reg  [0:QW];
    logic          neg_reg  [0:QW];
    logic          zero_reg [0:QW];
    logic [W-1:0]  vec_reg  [0:QW];
    logic          sat_reg  [0:QW];

    logic [W-1:0]  inv_reg;
    logic [W-1:0]  vecf_reg;
    logic          satf_reg;

    // operand set-up
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= '0;
            quo_reg[0]  <= '0;
            mag_reg[0]  <= vec_in[W-1] ? (~vec_in + W'(1)) : vec_in;
            neg_reg[0]  <= vec_in[W-1];
            zero_reg[0] <= vec_in == '0;
            vec_reg[0]  <= vec_in;
            sat_reg[0]  <= sat_in;
        end
    end

    // restoring division of 2^(2*frac) by the magnitude, one bit per stage
    for (genvar k = 1; k <= QW; k++)
    begin : g_div
        logic [W:0] rem_sh;
        logic       take;

        assign rem_sh = {rem_reg[k-1][W-1:0], (k == 1) ? 1'b1 : 1'b0};
        assign take   = rem_sh >= {1'b0, mag_reg[k-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= take ? (rem_sh - {1'b0, mag_reg[k-1]}) : rem_sh;
                quo_reg[k]  <= {quo_reg[k-1][QW-2:0], take};
                mag_reg[k]  <= mag_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
                vec_reg[k]  <= vec_reg[k-1];
                sat_reg[k]  <= sat_reg[k-1];
            end
        end
    end

    // clamp, sign and zero divisor handling
    logic [CW-1:0] quo_ext;
    logic [CW-1:0] quo_limit;
    logic [W-1:0]  inv_next;
    logic          clamp;

    always_comb
    begin
        quo_ext   = CW'(quo_reg[QW]);
        quo_limit = neg_reg[QW] ? HALF : HALF - CW'(1);
        clamp     = 1'b0;
        if (zero_reg[QW])
        begin
            clamp    = 1'b1;
            inv_next = VMAX;
        end
        else if (quo_ext > quo_limit)
        begin
            clamp    = 1'b1;
            inv_next = neg_reg[QW] ? VMIN : VMAX;
        end
        else
        begin
            inv_next = neg_reg[QW] ? (~quo_ext[W-1:0] + W'(1)) : quo_ext[W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inv_reg  <= inv_next;
            vecf_reg <= vec_reg[QW];
            satf_reg <= sat_reg[QW] | clamp;
        end
    end

    assign inv     = inv_reg;
    assign vec_out = vecf_reg;
    assign sat     = satf_reg;

endmodule

`default_nettype wire

[src/shadow_ray_generation_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Shadow ray generation: takes one primary ray per beat and returns the
// light-to-hit vector (origin + t*direction - light, saturating Q format)
// with its componentwise truncating reciprocal 2^(2*FRAC_BITS)/d, default
// Q16.16. A ray is accepted every cycle unless a finished result waits
// on out_ready, which holds the whole pipeline. The bit-per-stage divider
// follows the multiply, add and subtract stages. Misses give a zero
// vector, maximum reciprocals and saturated high. Write the light
// position only while no ray is in flight.
module shadow_ray_generation_unit import srg_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration
    input  wire logic                         cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [COORD_BITS-1:0]        cfg_data,
    // ray input
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         hit_flag,
    input  wire logic signed [COORD_BITS-1:0] hit_distance,
    input  wire logic signed [COORD_BITS-1:0] origin_x,
    input  wire logic signed [COORD_BITS-1:0] origin_y,
    input  wire logic signed [COORD_BITS-1:0] origin_z,
    input  wire logic signed [COORD_BITS-1:0] direction_x,
    input  wire logic signed [COORD_BITS-1:0] direction_y,
    input  wire logic signed [COORD_BITS-1:0] direction_z,
    input  wire logic                         last_in,
    // shadow ray output
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [COORD_BITS-1:0]      shadow_dir_x,
    output logic signed [COORD_BITS-1:0]      shadow_dir_y,
    output logic signed [COORD_BITS-1:0]      shadow_dir_z,
    output logic signed [COORD_BITS-1:0]      inverse_x,
    output logic signed [COORD_BITS-1:0]      inverse_y,
    output logic signed [COORD_BITS-1:0]      inverse_z,
    output logic                              saturated,
    output logic                              last_out
);

    localparam int LAT = 4 + (2 * FRAC_BITS + 1) + 2;

    // light position registers
    logic [COORD_BITS-1:0] light_x_reg;
    logic [COORD_BITS-1:0] light_y_reg;
    logic [COORD_BITS-1:0] light_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_x_reg <= '0;
            light_y_reg <= '0;
            light_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LIGHT_X: light_x_reg <= cfg_data;
                REG_LIGHT_Y: light_y_reg <= cfg_data;
                REG_LIGHT_Z: light_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advances unless a finished beat is held at the output
    logic advance;
    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    // valid and batch marker travel alongside the lanes
    logic [LAT-1:0] valid_reg;
    logic [LAT-1:0] valid_next;
    logic [LAT-1:0] last_reg;

    assign valid_next = {valid_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            last_reg <= {last_reg[LAT-2:0], last_in};
        end
    end

    // three component lanes
    logic signed [COORD_BITS-1:0] vec_x, vec_y, vec_z;
    logic                         psat_x, psat_y, psat_z;
    logic                         rsat_x, rsat_y, rsat_z;

    srg_point_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_pt_x (
        .clk(clk), .en(advance), .hit(hit_flag), .t(hit_distance),
        .org(origin_x), .dir(direction_x), .light(light_x_reg),
        .vec(vec_x), .sat(psat_x)
    );
    srg_point_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_pt_y (
        .clk(clk), .en(advance), .hit(hit_flag), .t(hit_distance),
        .org(origin_y), .dir(direction_y), .light(light_y_reg),
        .vec(vec_y), .sat(psat_y)
    );
    srg_point_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_pt_z (
        .clk(clk), .en(advance), .hit(hit_flag), .t(hit_distance),
        .org(origin_z), .dir(direction_z), .light(light_z_reg),
        .vec(vec_z), .sat(psat_z)
    );

    srg_recip_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_rc_x (
        .clk(clk), .en(advance), .vec_in(vec_x), .sat_in(psat_x),
        .vec_out(shadow_dir_x), .inv(inverse_x), .sat(rsat_x)
    );
    srg_recip_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_rc_y (
        .clk(clk), .en(advance), .vec_in(vec_y), .sat_in(psat_y),
        .vec_out(shadow_dir_y), .inv(inverse_y), .sat(rsat_y)
    );
    srg_recip_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_rc_z (
        .clk(clk), .en(advance), .vec_in(vec_z), .sat_in(psat_z),
        .vec_out(shadow_dir_z), .inv(inverse_z), .sat(rsat_z)
    );

    // output beat
    assign out_valid = valid_reg[LAT-1];
    assign last_out  = last_reg[LAT-1];
    assign saturated = rsat_x | rsat_y | rsat_z;

endmodule

`default_nettype wire

[src/srg_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module srg_checker import srg_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_ready,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [COORD_BITS-1:0] shadow_dir_x,
    input wire logic [COORD_BITS-1:0] inverse_x,
    input wire logic                  saturated
);

    localparam logic [COORD_BITS-1:0] VMAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    // a held output beat stays presented
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(inverse_x))
        else $error("output beat dropped or changed while stalled");

    // an empty output stage never blocks the input
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // a zero component has a clamped reciprocal
    a_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && shadow_dir_x == '0 |-> saturated)
        else $error("zero component without saturation");

    a_zero_inv: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && shadow_dir_x == '0 |-> inverse_x == VMAX)
        else $error("zero component reciprocal not maximum");

endmodule

bind shadow_ray_generation_unit srg_checker #(.COORD_BITS(COORD_BITS)) u_srg_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .shadow_dir_x(shadow_dir_x),
    .inverse_x(inverse_x),
    .saturated(saturated)
);

`default_nettype wire
